[design/ssr_pkg.sv]
package ssr_pkg;

	localparam int unsigned BM_BYTES = 6144;
	localparam int unsigned AT_BYTES = 768;
	localparam int unsigned SCREEN_BYTES = BM_BYTES + AT_BYTES;
	localparam int unsigned BM_AW = $clog2(BM_BYTES);
	localparam int unsigned AT_AW = $clog2(AT_BYTES);
	localparam int unsigned OFF_W = 13;
	localparam int unsigned COL_W = 5;
	localparam int unsigned NUM_PIX = 8;

	localparam logic [OFF_W-1:0] SCREEN_END = OFF_W'(SCREEN_BYTES);
	localparam logic [OFF_W-1:0] AT_BASE = OFF_W'(BM_BYTES);
	localparam logic [BM_AW-1:0] CLR_LAST = BM_AW'(BM_BYTES - 1);
	localparam logic [7:0] DISPLAY_LINES = 8'd192;
	localparam logic [COL_W-1:0] LAST_COL = '1;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_RENDER = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RENDER
	} ssr_state_t;

	typedef struct packed {
		logic             we;
		logic [OFF_W-1:0] addr;
		logic [7:0]       data;
	} ssr_wr_t;

	typedef struct packed {
		logic [7:0]       line;
		logic [COL_W-1:0] col;
		logic             flash;
		logic             last;
	} ssr_cell_t;

	function automatic logic [15:0] ssr_palette(input logic [3:0] idx);
		logic [15:0] c;
		case (idx)
			4'd0:    c = 16'h0000;
			4'd1:    c = 16'h0019;
			4'd2:    c = 16'hC800;
			4'd3:    c = 16'hC819;
			4'd4:    c = 16'h0660;
			4'd5:    c = 16'h0679;
			4'd6:    c = 16'hCE60;
			4'd7:    c = 16'hCE79;
			4'd8:    c = 16'h0000;
			4'd9:    c = 16'h001F;
			4'd10:   c = 16'hF800;
			4'd11:   c = 16'hF81F;
			4'd12:   c = 16'h07E0;
			4'd13:   c = 16'h07FF;
			4'd14:   c = 16'hFFE0;
			4'd15:   c = 16'hFFFF;
			default: c = 16'h0000;
		endcase
		return c;
	endfunction

endpackage

[design/spectrum_scanline_renderer_top.sv]
// ZX Spectrum scanline renderer. After reset the screen memory is cleared in a
// pass over the 6144 bitmap addresses during which s_tready stays low. A write
// item (tuser 0) stores one byte; offsets past 6911 are dropped. A render item
// (tuser 1) for lines 0..191 reads the bitmap and attribute arrays side by side,
// one character cell per cycle unless the output stalls, and yields 32 items on
// the master side through the registered reads and the pixel register; lines
// 192..255 yield nothing. Output stalls hold the cell sequencer. Writes are
// accepted while the last cells of a line are still waiting on the master side.
module spectrum_scanline_renderer_top
	import ssr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,  // write_offset[12:0], write_data[20:13], line[28:21], flash_phase[29]
	input  logic         s_tuser,  // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,  // out_line[7:0], cell_column[12:8], pix0..pix7 16 bits each from bit 13
	output logic         m_tlast   // last_cell
);

	ssr_state_t       state_q;
	ssr_state_t       state_d;
	logic [COL_W-1:0] col_q;
	logic [7:0]       line_q;
	logic             flash_q;

	logic             s1_valid;
	ssr_cell_t        s1_cell;

	logic             accept;
	logic             render_ok;
	logic             issue;
	logic             s2_ready;
	logic             clr_done;
	ssr_wr_t          wr;

	logic [OFF_W-1:0] in_off;
	logic [7:0]       in_data;
	logic [7:0]       in_line;
	logic             in_flash;

	logic [7:0]       bm_rdata;
	logic [7:0]       at_rdata;
	logic [7:0]       out_line;
	logic [COL_W-1:0] out_col;
	logic [NUM_PIX*16-1:0] out_pix;

	assign in_off = s_tdata[12:0];
	assign in_data = s_tdata[20:13];
	assign in_line = s_tdata[28:21];
	assign in_flash = s_tdata[29];

	assign accept = s_tvalid && s_tready;
	assign render_ok = (s_tuser == REQ_RENDER) && (in_line < DISPLAY_LINES);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && render_ok) begin
					state_d = ST_RENDER;
				end
			end
			ST_RENDER: begin
				if (issue && col_q == LAST_COL) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		// a cell read may go out when the read stage is empty or draining
		issue = (state_q == ST_RENDER) && (!s1_valid || s2_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			col_q <= '0;
			line_q <= '0;
			flash_q <= 1'b0;
			s1_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && render_ok) begin
				col_q <= '0;
				line_q <= in_line;
				flash_q <= in_flash;
			end else if (issue) begin
				col_q <= col_q + 1'b1;
			end
			if (issue) begin
				s1_valid <= 1'b1;
			end else if (s2_ready) begin
				s1_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_cell.line <= line_q;
			s1_cell.col <= col_q;
			s1_cell.flash <= flash_q;
			s1_cell.last <= (col_q == LAST_COL);
		end
	end

	always_comb begin
		wr.we = accept && (s_tuser == REQ_WRITE);
		wr.addr = in_off;
		wr.data = in_data;
	end

	ssr_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_en    (issue),
		.bm_raddr ({line_q[7:6], line_q[2:0], line_q[5:3], col_q}),
		.at_raddr ({line_q[7:3], col_q}),
		.bm_rdata (bm_rdata),
		.at_rdata (at_rdata),
		.clr_done (clr_done)
	);

	ssr_pix_stage u_pix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s1_valid),
		.in_cell   (s1_cell),
		.bm_byte   (bm_rdata),
		.at_byte   (at_rdata),
		.in_ready  (s2_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_line  (out_line),
		.out_col   (out_col),
		.out_pix   (out_pix),
		.out_last  (m_tlast)
	);

	assign m_tdata = {3'b000, out_pix, out_col, out_line};

endmodule

[design/ssr_mem.sv]
module ssr_mem
	import ssr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ssr_wr_t          wr,
	input  logic             rd_en,
	input  logic [BM_AW-1:0] bm_raddr,
	input  logic [AT_AW-1:0] at_raddr,
	output logic [7:0]       bm_rdata,
	output logic [7:0]       at_rdata,
	output logic             clr_done
);

	logic [7:0] bm_mem [BM_BYTES];
	logic [7:0] at_mem [AT_BYTES];

	logic             clr_busy_q;
	logic [BM_AW-1:0] clr_cnt_q;

	logic             bm_we;
	logic             at_we;
	logic [BM_AW-1:0] bm_waddr;
	logic [AT_AW-1:0] at_waddr;
	logic [7:0]       wdata;
	logic [OFF_W-1:0] at_off;

	assign clr_done = !clr_busy_q;
	assign at_off = wr.addr - AT_BASE;

	always_comb begin
		if (clr_busy_q) begin
			bm_we = 1'b1;
			at_we = (clr_cnt_q < BM_AW'(AT_BYTES));
			bm_waddr = clr_cnt_q;
			at_waddr = clr_cnt_q[AT_AW-1:0];
			wdata = '0;
		end else begin
			bm_we = wr.we && (wr.addr < AT_BASE);
			at_we = wr.we && (wr.addr >= AT_BASE) && (wr.addr < SCREEN_END);
			bm_waddr = wr.addr[BM_AW-1:0];
			at_waddr = at_off[AT_AW-1:0];
			wdata = wr.data;
		end
	end

	// one pass over both arrays after reset; attribute array finishes first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CLR_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= wdata;
		end
		if (rd_en) begin
			bm_rdata <= bm_mem[bm_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (at_we) begin
			at_mem[at_waddr] <= wdata;
		end
		if (rd_en) begin
			at_rdata <= at_mem[at_raddr];
		end
	end

endmodule

[design/ssr_pix_stage.sv]
module ssr_pix_stage
	import ssr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ssr_cell_t         in_cell,
	input  logic [7:0]        bm_byte,
	input  logic [7:0]        at_byte,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_line,
	output logic [COL_W-1:0]  out_col,
	output logic [NUM_PIX*16-1:0] out_pix,
	output logic              out_last
);

	logic                  valid_q;
	logic [7:0]            line_q;
	logic [COL_W-1:0]      col_q;
	logic                  last_q;
	logic [NUM_PIX*16-1:0] pix_q;

	logic [15:0]           ink;
	logic [15:0]           paper;
	logic [15:0]           fg;
	logic [15:0]           bg;
	logic [NUM_PIX*16-1:0] pix_d;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		ink = ssr_palette({at_byte[6], at_byte[2:0]});
		paper = ssr_palette({at_byte[6], at_byte[5:3]});
		if (at_byte[7] && in_cell.flash) begin
			fg = paper;
			bg = ink;
		end else begin
			fg = ink;
			bg = paper;
		end
		// pixel 0 (lowest slot) comes from bitmap bit 7
		for (int k = 0; k < NUM_PIX; k++) begin
			pix_d[k*16 +: 16] = bm_byte[NUM_PIX-1-k] ? fg : bg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			line_q <= in_cell.line;
			col_q <= in_cell.col;
			last_q <= in_cell.last;
			pix_q <= pix_d;
		end
	end

	assign out_valid = valid_q;
	assign out_line = line_q;
	assign out_col = col_q;
	assign out_pix = pix_q;
	assign out_last = last_q;

endmodule
